### rtl/lnpe_pkg.sv
// Shared types and constants for the lattice neighbor pair energy block.
`default_nettype none

package lnpe_pkg;

  localparam int DEFAULT_MAX_SIDE = 32;
  localparam int COORD_W          = 5;
  localparam int SIZE_W           = 6;
  localparam int ENERGY_W         = 16;
  localparam int SUM_W            = 19;
  localparam int CFG_INDEX_W      = 4;
  localparam int CFG_DATA_W       = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] TYPE_OTHER = 2'd0;
  localparam logic [1:0] TYPE_WATER = 2'd1;
  localparam logic [1:0] TYPE_TAIL  = 2'd2;
  localparam logic [1:0] TYPE_OIL   = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENERGY_WW = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENERGY_OW = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENERGY_TT = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENERGY_OT = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENERGY_OO = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_X    = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_Y    = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_Z    = 4'd7;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [COORD_W-1:0] z_coord;
    logic [1:0]         new_type;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] energy_sum;
    logic [1:0]              centre_type;
  } out_item_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] water_water;
    logic signed [ENERGY_W-1:0] oil_water;
    logic signed [ENERGY_W-1:0] tail_tail;
    logic signed [ENERGY_W-1:0] oil_tail;
    logic signed [ENERGY_W-1:0] oil_oil;
  } energy_set_t;

  typedef struct packed {
    logic load_centre;
    logic add_one;
  } acc_ctl_t;

endpackage

`default_nettype wire

### rtl/lnpe_row_ram.sv
// Single-port-write, single-port-read row memory with registered read data.
`default_nettype none

module lnpe_row_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/lnpe_pair_accum.sv
// Pair energy lookup and running sum over the neighbors of one site.
`default_nettype none

module lnpe_pair_accum (
  input  wire logic                                 clk,
  input  wire lnpe_pkg::acc_ctl_t                   ctl,
  input  wire lnpe_pkg::energy_set_t                energy,
  input  wire logic [1:0]                           centre_in,
  input  wire logic [1:0]                           nb_a,
  input  wire logic [1:0]                           nb_b,
  output logic signed [lnpe_pkg::SUM_W-1:0]         sum,
  output logic [1:0]                                centre
);

  logic signed [lnpe_pkg::SUM_W-1:0] sum_r;
  logic signed [lnpe_pkg::SUM_W-1:0] sum_nxt;
  logic [1:0]                        centre_r;
  logic [1:0]                        centre_nxt;

  function automatic logic signed [lnpe_pkg::SUM_W-1:0] pair_energy(
    input logic [1:0]           a,
    input logic [1:0]           b,
    input lnpe_pkg::energy_set_t e
  );
    logic signed [lnpe_pkg::ENERGY_W-1:0] v;
    if (a == lnpe_pkg::TYPE_OTHER || b == lnpe_pkg::TYPE_OTHER) begin
      v = '0;
    end else if (a == lnpe_pkg::TYPE_WATER && b == lnpe_pkg::TYPE_WATER) begin
      v = e.water_water;
    end else if (a == lnpe_pkg::TYPE_WATER || b == lnpe_pkg::TYPE_WATER) begin
      v = e.oil_water;
    end else if (a == lnpe_pkg::TYPE_TAIL && b == lnpe_pkg::TYPE_TAIL) begin
      v = e.tail_tail;
    end else if (a == lnpe_pkg::TYPE_OIL && b == lnpe_pkg::TYPE_OIL) begin
      v = e.oil_oil;
    end else begin
      v = e.oil_tail;
    end
    return {{(lnpe_pkg::SUM_W-lnpe_pkg::ENERGY_W){v[lnpe_pkg::ENERGY_W-1]}}, v};
  endfunction

  always_comb begin
    sum_nxt    = sum_r;
    centre_nxt = centre_r;
    if (ctl.load_centre) begin
      // centre row carries the site and both z neighbors
      centre_nxt = centre_in;
      sum_nxt    = pair_energy(centre_in, nb_a, energy) + pair_energy(centre_in, nb_b, energy);
    end else if (ctl.add_one) begin
      sum_nxt = sum_r + pair_energy(centre_r, nb_a, energy);
    end
  end

  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    centre_r <= centre_nxt;
  end

  assign sum    = sum_r;
  assign centre = centre_r;

endmodule

`default_nettype wire

### rtl/lattice_neighbor_pair_energy_core.sv
// Top level: site type lattice in a row memory, neighbor reads and pair energy sum.
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+------------------------------------
//  in      | in_valid, in_ready, in_data             | write or query item
//  out     | out_valid, out_ready, out_data          | energy sum and centre type per query
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, always ready
//
// The lattice is stored one (x, y) row per memory word, all z sites of the row side by side,
// so a query reads five rows (centre row, then x-1, y-1, x+1, y+1) through the single read
// port before the sum goes to the result register. A write item reads the row, merges the new
// type and writes the row back. After reset the memory is swept to zero, one row a cycle,
// all MAX_SIDE*MAX_SIDE rows (1024 at the default) with in_ready low. A result waiting on
// out_ready does not block the next item; only a second finished query waits for it.
`default_nettype none

module lattice_neighbor_pair_energy_core #(
  parameter int MAX_SIDE = lnpe_pkg::DEFAULT_MAX_SIDE
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire lnpe_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output lnpe_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lnpe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [lnpe_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int ROWS  = MAX_SIDE * MAX_SIDE;
  localparam int RAW   = $clog2(ROWS);
  localparam int ROW_W = 2 * MAX_SIDE;
  localparam int NCOORD = 2 ** lnpe_pkg::COORD_W;

  typedef logic [MAX_SIDE-1:0][1:0] row_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_DRAIN, S_DONE, S_WRD, S_WMOD
  } state_t;

  typedef enum logic [2:0] {
    STEP_C, STEP_XM, STEP_YM, STEP_XP, STEP_YP
  } step_t;

  // configuration registers
  lnpe_pkg::energy_set_t             energy_r;
  logic [lnpe_pkg::SIZE_W-1:0]       size_x_r;
  logic [lnpe_pkg::SIZE_W-1:0]       size_y_r;
  logic [lnpe_pkg::SIZE_W-1:0]       size_z_r;

  state_t                            state_r, state_nxt;
  step_t                             step_r, step_nxt;
  logic [RAW-1:0]                    clr_addr_r, clr_addr_nxt;
  logic                              dvld_r, dvld_nxt;
  step_t                             dstep_r, dstep_nxt;
  logic                              out_valid_r, out_valid_nxt;
  lnpe_pkg::out_item_t               out_r;

  logic [CW-1:0]                     x_r, y_r, z_r;
  logic [1:0]                        new_type_r;

  logic [CW-1:0]                     fold_tab [NCOORD];
  logic [SW-1:0]                     eff_x, eff_y, eff_z;
  logic [CW-1:0]                     xm, xp, ym, yp, zm, zp;
  logic [CW-1:0]                     rd_x, rd_y;
  logic [RAW-1:0]                    centre_addr, rd_addr;

  logic                              ram_we;
  logic [RAW-1:0]                    ram_waddr;
  row_t                              ram_wdata;
  row_t                              ram_rdata;
  row_t                              merged_row;

  logic                              in_acc;
  logic                              out_load;
  lnpe_pkg::acc_ctl_t                acc_ctl;
  logic [1:0]                        nb_a;
  logic signed [lnpe_pkg::SUM_W-1:0] acc_sum;
  logic [1:0]                        acc_centre;

  // coordinates beyond the store wrap at MAX_SIDE
  for (genvar i = 0; i < NCOORD; i++) begin : g_fold
    assign fold_tab[i] = CW'(i % MAX_SIDE);
  end

  function automatic logic [SW-1:0] eff_side(input logic [lnpe_pkg::SIZE_W-1:0] s);
    if (s == '0 || 32'(s) > MAX_SIDE) begin
      return SW'(MAX_SIDE);
    end
    return SW'(s);
  endfunction

  function automatic logic [CW-1:0] plus_one(input logic [CW-1:0] c, input logic [SW-1:0] s);
    if (32'(c) + 32'd1 >= 32'(s)) begin
      return '0;
    end
    return CW'(32'(c) + 32'd1);
  endfunction

  function automatic logic [CW-1:0] minus_one(input logic [CW-1:0] c, input logic [SW-1:0] s);
    if (c == '0) begin
      return CW'(s - SW'(1));
    end
    return c - CW'(1);
  endfunction

  function automatic logic [RAW-1:0] row_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return RAW'(x) * RAW'(MAX_SIDE) + RAW'(y);
  endfunction

  assign eff_x = eff_side(size_x_r);
  assign eff_y = eff_side(size_y_r);
  assign eff_z = eff_side(size_z_r);

  assign xm = minus_one(x_r, eff_x);
  assign xp = plus_one(x_r, eff_x);
  assign ym = minus_one(y_r, eff_y);
  assign yp = plus_one(y_r, eff_y);
  assign zm = minus_one(z_r, eff_z);
  assign zp = plus_one(z_r, eff_z);

  always_comb begin
    rd_x = x_r;
    rd_y = y_r;
    if (state_r == S_RD) begin
      case (step_r)
        STEP_XM: rd_x = xm;
        STEP_YM: rd_y = ym;
        STEP_XP: rd_x = xp;
        STEP_YP: rd_y = yp;
        default: begin
          rd_x = x_r;
          rd_y = y_r;
        end
      endcase
    end
  end

  assign centre_addr = row_addr(x_r, y_r);
  assign rd_addr     = row_addr(rd_x, rd_y);

  always_comb begin
    merged_row       = ram_rdata;
    merged_row[z_r]  = new_type_r;
  end

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_WMOD);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : centre_addr;
  assign ram_wdata = (state_r == S_CLEAR) ? row_t'('0) : merged_row;

  lnpe_row_ram #(
    .DEPTH (ROWS),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign acc_ctl.load_centre = dvld_r && (dstep_r == STEP_C);
  assign acc_ctl.add_one     = dvld_r && (dstep_r != STEP_C);
  assign nb_a = (dstep_r == STEP_C) ? ram_rdata[zm] : ram_rdata[z_r];

  lnpe_pair_accum u_accum (
    .clk       (clk),
    .ctl       (acc_ctl),
    .energy    (energy_r),
    .centre_in (ram_rdata[z_r]),
    .nb_a      (nb_a),
    .nb_b      (ram_rdata[zp]),
    .sum       (acc_sum),
    .centre    (acc_centre)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    clr_addr_nxt  = clr_addr_r;
    dvld_nxt      = 1'b0;
    dstep_nxt     = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + RAW'(1);
        if (clr_addr_r == RAW'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          step_nxt  = STEP_C;
          state_nxt = (in_data.mode == lnpe_pkg::MODE_QUERY) ? S_RD : S_WRD;
        end
      end
      S_RD: begin
        dvld_nxt = 1'b1;
        if (step_r == STEP_YP) begin
          state_nxt = S_DRAIN;
        end else begin
          step_nxt = step_t'(step_r + 3'd1);
        end
      end
      S_DRAIN: state_nxt = S_DONE;
      S_DONE: begin
        // hold the sum until the result register frees up
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_WRD:  state_nxt = S_WMOD;
      S_WMOD: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      step_r      <= STEP_C;
      clr_addr_r  <= '0;
      dvld_r      <= 1'b0;
      dstep_r     <= STEP_C;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      clr_addr_r  <= clr_addr_nxt;
      dvld_r      <= dvld_nxt;
      dstep_r     <= dstep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r        <= fold_tab[in_data.x_coord];
      y_r        <= fold_tab[in_data.y_coord];
      z_r        <= fold_tab[in_data.z_coord];
      new_type_r <= in_data.new_type;
    end
    if (out_load) begin
      out_r.energy_sum  <= acc_sum;
      out_r.centre_type <= acc_centre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= '0;
      size_x_r <= lnpe_pkg::SIZE_RESET;
      size_y_r <= lnpe_pkg::SIZE_RESET;
      size_z_r <= lnpe_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lnpe_pkg::CFG_ENERGY_WW: energy_r.water_water <= cfg_data;
        lnpe_pkg::CFG_ENERGY_OW: energy_r.oil_water   <= cfg_data;
        lnpe_pkg::CFG_ENERGY_TT: energy_r.tail_tail   <= cfg_data;
        lnpe_pkg::CFG_ENERGY_OT: energy_r.oil_tail    <= cfg_data;
        lnpe_pkg::CFG_ENERGY_OO: energy_r.oil_oil     <= cfg_data;
        lnpe_pkg::CFG_SIZE_X:    size_x_r <= cfg_data[lnpe_pkg::SIZE_W-1:0];
        lnpe_pkg::CFG_SIZE_Y:    size_y_r <= cfg_data[lnpe_pkg::SIZE_W-1:0];
        lnpe_pkg::CFG_SIZE_Z:    size_z_r <= cfg_data[lnpe_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");

  a_no_write_during_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_DRAIN) |-> !ram_we)
    else $error("lattice written while a query reads it");

  a_read_data_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    dvld_r |-> (state_r == S_RD || state_r == S_DRAIN))
    else $error("neighbor data returned outside a query");

  a_query_starts_at_centre: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.mode == lnpe_pkg::MODE_QUERY)
      |=> (state_r == S_RD && step_r == STEP_C))
    else $error("query did not start with the centre row");

  a_done_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> ($past(state_r == S_DRAIN) || $past(state_r == S_DONE)))
    else $error("done state entered before the last row was summed");

endmodule

`default_nettype wire

### tb/tb_lattice_neighbor_pair_energy_core.sv
// Self-checking testbench for the lattice neighbor pair energy core.
module tb_lattice_neighbor_pair_energy_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lnpe_pkg::*;

  localparam int unsigned SIDE           = DEFAULT_MAX_SIDE;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam int unsigned MAX_REPORTS    = 10;

  // Indexes past the last register: writes to them must leave everything unchanged.
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG_LO = 4'd8;
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG_HI = 4'd15;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Mirror of the block's state and registers
  logic [1:0]  site_mirror [SIDE*SIDE*SIDE] = '{default: '0};
  energy_set_t pair_tab = '0;
  logic [SIZE_W-1:0] extent_x = SIZE_RESET;
  logic [SIZE_W-1:0] extent_y = SIZE_RESET;
  logic [SIZE_W-1:0] extent_z = SIZE_RESET;

  in_item_t    site_item_q [$];
  out_item_t   energy_expect_q [$];
  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors   = 0;
  int unsigned n_cycles   = 0;
  int unsigned idle_pct   = 33;
  logic        hold_armed = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left  = 0;

  lattice_neighbor_pair_energy_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned span_of(logic [SIZE_W-1:0] s);
    return (s == 0 || s > SIDE) ? SIDE : int'(s);
  endfunction

  function automatic int unsigned step_up(int unsigned c, int unsigned s);
    return (c + 1 >= s) ? 0 : c + 1;
  endfunction

  function automatic int unsigned step_down(int unsigned c, int unsigned s);
    return (c == 0) ? s - 1 : c - 1;
  endfunction

  function automatic logic [1:0] site_at(int unsigned x, int unsigned y, int unsigned z);
    return site_mirror[(x * SIDE + y) * SIDE + z];
  endfunction

  function automatic int pair_energy(logic [1:0] a, logic [1:0] b);
    if (a == TYPE_OTHER || b == TYPE_OTHER) return 0;
    if (a == TYPE_WATER && b == TYPE_WATER) return int'(pair_tab.water_water);
    if (a == TYPE_WATER || b == TYPE_WATER) return int'(pair_tab.oil_water);
    if (a == TYPE_TAIL && b == TYPE_TAIL) return int'(pair_tab.tail_tail);
    if (a == TYPE_OIL && b == TYPE_OIL) return int'(pair_tab.oil_oil);
    return int'(pair_tab.oil_tail);
  endfunction

  task automatic predict_item(input in_item_t it);
    int unsigned x, y, z, sx, sy, sz;
    logic [1:0]  c;
    int          total;
    out_item_t   r;
    x = it.x_coord % SIDE;
    y = it.y_coord % SIDE;
    z = it.z_coord % SIDE;
    if (it.mode == MODE_WRITE) begin
      site_mirror[(x * SIDE + y) * SIDE + z] = it.new_type;
    end else begin
      sx = span_of(extent_x);
      sy = span_of(extent_y);
      sz = span_of(extent_z);
      c = site_at(x, y, z);
      total = pair_energy(c, site_at(step_down(x, sx), y, z))
            + pair_energy(c, site_at(x, step_down(y, sy), z))
            + pair_energy(c, site_at(x, y, step_down(z, sz)))
            + pair_energy(c, site_at(step_up(x, sx), y, z))
            + pair_energy(c, site_at(x, step_up(y, sy), z))
            + pair_energy(c, site_at(x, y, step_up(z, sz)));
      r.energy_sum  = total[SUM_W-1:0];
      r.centre_type = c;
      energy_expect_q.push_back(r);
    end
  endtask

  task automatic log_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  // Sender: hold the item until accepted, then advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (site_item_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= site_item_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result, stall at random, one long hold when armed
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (energy_expect_q.size() == 0) begin
          log_mismatch($sformatf("result with none pending: energy_sum %0d centre_type %0d",
                                 out_data.energy_sum, out_data.centre_type));
        end else begin
          want = energy_expect_q.pop_front();
          if (out_data.energy_sum !== want.energy_sum)
            log_mismatch($sformatf("energy_sum expected %0d got %0d",
                                   want.energy_sum, out_data.energy_sum));
          if (out_data.centre_type !== want.centre_type)
            log_mismatch($sformatf("centre_type expected %0d got %0d",
                                   want.centre_type, out_data.centre_type));
        end
      end
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_ENERGY_WW: pair_tab.water_water = val;
      CFG_ENERGY_OW: pair_tab.oil_water   = val;
      CFG_ENERGY_TT: pair_tab.tail_tail   = val;
      CFG_ENERGY_OT: pair_tab.oil_tail    = val;
      CFG_ENERGY_OO: pair_tab.oil_oil     = val;
      CFG_SIZE_X:    extent_x = val[SIZE_W-1:0];
      CFG_SIZE_Y:    extent_y = val[SIZE_W-1:0];
      CFG_SIZE_Z:    extent_z = val[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_energies(input int ww, input int ow, input int tt, input int ot,
                              input int oo);
    write_reg(CFG_ENERGY_WW, 16'(ww));
    write_reg(CFG_ENERGY_OW, 16'(ow));
    write_reg(CFG_ENERGY_TT, 16'(tt));
    write_reg(CFG_ENERGY_OT, 16'(ot));
    write_reg(CFG_ENERGY_OO, 16'(oo));
  endtask

  task automatic set_extents(input int unsigned sx, input int unsigned sy, input int unsigned sz);
    write_reg(CFG_SIZE_X, 16'(sx));
    write_reg(CFG_SIZE_Y, 16'(sy));
    write_reg(CFG_SIZE_Z, 16'(sz));
  endtask

  task automatic queue_item(input logic mode, input int unsigned x, input int unsigned y,
                            input int unsigned z, input logic [1:0] kind);
    in_item_t it;
    it.mode     = mode;
    it.x_coord  = 5'(x);
    it.y_coord  = 5'(y);
    it.z_coord  = 5'(z);
    it.new_type = kind;
    site_item_q.push_back(it);
    n_queued++;
  endtask

  // Mostly near the origin, some near the far wall, some anywhere
  function automatic int unsigned pick_coord(int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, span - 1);
    if (r < 85) return 31 - $urandom_range(0, span - 1);
    return $urandom_range(0, 31);
  endfunction

  function automatic int rand_energy();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    return int'(16'($urandom)) - 32768;
  endfunction

  function automatic int unsigned pick_extent();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return $urandom_range(33, 63);
    if (r < 20) return SIDE;
    return $urandom_range(1, 8);
  endfunction

  task automatic queue_random(input int unsigned n, input int unsigned span);
    repeat (n) begin
      queue_item(($urandom_range(0, 99) < 55) ? MODE_WRITE : MODE_QUERY,
                 pick_coord(span), pick_coord(span), pick_coord(span),
                 2'($urandom_range(0, 3)));
    end
  endtask

  // Wait until every item is in and every result out, then let a write item finish
  task automatic drain();
    while (n_accepted != n_queued || energy_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    set_energies(384, -256, 128, 77, -640);
    write_reg(CFG_NO_REG_LO, 16'hFFFF);
    write_reg(CFG_NO_REG_HI, 16'h5A5A);
    set_extents(SIDE, SIDE, SIDE);

    // Unwritten site, then a water site with a wrapped neighbor on every minus side
    queue_item(MODE_QUERY, 0, 0, 0, TYPE_OIL);
    queue_item(MODE_WRITE, 0, 0, 0, TYPE_WATER);
    queue_item(MODE_WRITE, 31, 0, 0, TYPE_WATER);
    queue_item(MODE_WRITE, 0, 31, 0, TYPE_TAIL);
    queue_item(MODE_WRITE, 0, 0, 31, TYPE_OIL);
    queue_item(MODE_WRITE, 1, 0, 0, TYPE_OIL);
    queue_item(MODE_WRITE, 0, 1, 0, TYPE_TAIL);
    queue_item(MODE_WRITE, 0, 0, 1, TYPE_OTHER);
    queue_item(MODE_QUERY, 0, 0, 0, TYPE_OIL);
    queue_item(MODE_QUERY, 31, 0, 0, TYPE_TAIL);
    // Far corner: plus neighbors wrap to zero
    queue_item(MODE_WRITE, 31, 31, 31, TYPE_OIL);
    queue_item(MODE_WRITE, 30, 31, 31, TYPE_OIL);
    queue_item(MODE_WRITE, 31, 30, 31, TYPE_TAIL);
    queue_item(MODE_WRITE, 31, 31, 30, TYPE_OIL);
    queue_item(MODE_QUERY, 31, 31, 31, TYPE_WATER);
    queue_item(MODE_QUERY, 0, 31, 0, TYPE_OTHER);
    queue_item(MODE_QUERY, 0, 0, 31, TYPE_OTHER);
    // An empty centre pairs with nothing
    queue_item(MODE_WRITE, 0, 0, 0, TYPE_OTHER);
    queue_item(MODE_QUERY, 0, 0, 0, TYPE_WATER);
    drain();

    // Extent one: all six neighbors are the site itself, so the sum hits both extremes
    set_extents(1, 1, 1);
    set_energies(-32768, -32768, -32768, -32768, -32768);
    queue_item(MODE_WRITE, 0, 0, 0, TYPE_OIL);
    queue_item(MODE_QUERY, 0, 0, 0, TYPE_OTHER);
    drain();
    set_energies(32767, 32767, 32767, 32767, 32767);
    queue_item(MODE_WRITE, 0, 0, 0, TYPE_WATER);
    queue_item(MODE_QUERY, 0, 0, 0, TYPE_OTHER);
    drain();

    // Small extents, coordinates past them, and one long receiver hold
    set_energies(-32768, 32767, -32768, 32767, -32768);
    set_extents(3, 1, 2);
    queue_random(200, 4);
    hold_armed <= 1'b1;
    drain();

    // Extents that fall back to the full side, with no idling on either side
    idle_pct <= 0;
    set_energies(rand_energy(), rand_energy(), rand_energy(), rand_energy(), rand_energy());
    set_extents(0, 63, 33);
    queue_random(150, 3);
    drain();
    idle_pct <= 33;

    repeat (3) begin
      set_energies(rand_energy(), rand_energy(), rand_energy(), rand_energy(), rand_energy());
      set_extents(pick_extent(), pick_extent(), pick_extent());
      queue_random(200, $urandom_range(2, 6));
      drain();
    end

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lnpe_pkg.sv
rtl/lnpe_row_ram.sv
rtl/lnpe_pair_accum.sv
rtl/lattice_neighbor_pair_energy_core.sv
tb/tb_lattice_neighbor_pair_energy_core.sv
